// File: design/pfh_pkg.sv
// Shared types, constants and helper functions for the path segment hasher.
`default_nettype none

package pfh_pkg;

   // FNV-1a 32-bit constants
   localparam logic [31:0] FnvOffsetBasis = 32'd2166136261;
   localparam logic [31:0] FnvPrime       = 32'd16777619;

   // Segment boundary characters
   localparam logic [7:0] CharSlash     = 8'h2F;
   localparam logic [7:0] CharBackslash = 8'h5C;
   localparam logic [7:0] CharDot       = 8'h2E;
   localparam logic [7:0] CharStar      = 8'h2A;
   localparam logic [7:0] CharNul       = 8'h00;

   // ASCII bases for hex digits
   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharLowerA = 8'h61;

   // One boundary event handed from the front to the back
   typedef struct packed {
      logic [31:0] hash;
      logic        nonempty;
      logic [7:0]  sep;
   } qentry_type;

   // Back-end emit phase
   typedef enum logic {
      PH_HEX,
      PH_SEP
   } phase_type;

   function automatic logic is_boundary(input logic [7:0] b);
      return (b == CharSlash) || (b == CharBackslash) || (b == CharDot) ||
             (b == CharStar) || (b == CharNul);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] ext;
      ext = {4'h0, nib};
      if (nib < 4'd10) begin
         return CharZero + ext;
      end
      return CharLowerA + ext - 8'd10;
   endfunction

   // Index of the most significant nonzero nibble, zero when the word is zero
   function automatic logic [2:0] top_nibble(input logic [31:0] h);
      logic [2:0] top;
      top = 3'd0;
      for (int i = 1; i < 8; i++) begin
         if (h[4*i +: 4] != 4'h0) begin
            top = 3'(i);
         end
      end
      return top;
   endfunction

endpackage

`default_nettype wire

// File: design/pfh_front.sv
// Front end: accepts path bytes, folds segment bytes into the hash, queues boundaries.
`default_nettype none

module pfh_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_path_byte,
   output logic                    push_valid,
   input  wire logic               push_ready,
   output pfh_pkg::qentry_type     push_data
);
   import pfh_pkg::*;

   logic [31:0] hash_ff, hash_in;
   logic        nonempty_ff, nonempty_in;
   logic        boundary;
   logic        accept;
   logic [31:0] mixed;

   // Segment bytes never need the queue; boundaries wait for a free slot
   assign boundary  = is_boundary(req_path_byte);
   assign req_ready = push_ready || !boundary;
   assign accept    = req_valid && req_ready;

   assign push_valid         = req_valid && boundary;
   assign push_data.hash     = hash_ff;
   assign push_data.nonempty = nonempty_ff;
   assign push_data.sep      = req_path_byte;

   // Hash update
   always_comb begin
      mixed       = hash_ff ^ {24'h0, req_path_byte};
      hash_in     = hash_ff;
      nonempty_in = nonempty_ff;
      if (accept) begin
         if (boundary) begin
            hash_in     = FnvOffsetBasis;
            nonempty_in = 1'b0;
         end else begin
            hash_in     = 32'(mixed * FnvPrime);
            nonempty_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff     <= FnvOffsetBasis;
         nonempty_ff <= 1'b0;
      end else begin
         hash_ff     <= hash_in;
         nonempty_ff <= nonempty_in;
      end
   end

endmodule

`default_nettype wire

// File: design/pfh_fifo.sv
// Small queue of boundary events between the front and back ends.
`default_nettype none

module pfh_fifo #(
   parameter int Depth = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   output logic                      push_ready,
   input  wire pfh_pkg::qentry_type  push_data,
   output logic                      pop_valid,
   input  wire logic                 pop_ready,
   output pfh_pkg::qentry_type       pop_data
);
   import pfh_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   qentry_type          mem_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != FullCnt);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: design/pfh_back.sv
// Back end: turns queued boundaries into hex digits plus separator, one char per cycle when not stalled.
`default_nettype none

module pfh_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 pop_valid,
   output logic                      pop_ready,
   input  wire pfh_pkg::qentry_type  pop_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [7:0]                rsp_out_char,
   output logic                      rsp_path_end
);
   import pfh_pkg::*;

   logic        work_valid_ff, work_valid_in;
   phase_type   phase_ff, phase_in;
   logic [2:0]  digit_ff, digit_in;
   logic [31:0] hash_ff, hash_in;
   logic [7:0]  sep_ff, sep_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  char_ff, char_in;
   logic        end_ff, end_in;

   logic        out_free;
   logic        emit;
   logic        finish;
   logic [31:0] shifted;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_path_end = end_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = work_valid_ff && out_free;
   assign finish    = emit && (phase_ff == PH_SEP);
   assign pop_ready = !work_valid_ff || finish;
   assign shifted   = hash_ff >> {digit_ff, 2'b00};

   // Emit sequencer and output register
   always_comb begin
      work_valid_in = work_valid_ff;
      phase_in      = phase_ff;
      digit_in      = digit_ff;
      hash_in       = hash_ff;
      sep_in        = sep_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      char_in       = char_ff;
      end_in        = end_ff;

      if (emit) begin
         rsp_valid_in = 1'b1;
         unique case (phase_ff)
            PH_HEX: begin
               char_in = hex_char(shifted[3:0]);
               end_in  = 1'b0;
               if (digit_ff == 3'd0) begin
                  phase_in = PH_SEP;
               end else begin
                  digit_in = digit_ff - 3'd1;
               end
            end
            PH_SEP: begin
               char_in       = sep_ff;
               end_in        = (sep_ff == CharNul);
               work_valid_in = 1'b0;
            end
            default: begin
               work_valid_in = 1'b0;
            end
         endcase
      end

      // Load the next boundary, possibly in the same cycle the last one finishes
      if (pop_valid && pop_ready) begin
         work_valid_in = 1'b1;
         hash_in       = pop_data.hash;
         sep_in        = pop_data.sep;
         digit_in      = top_nibble(pop_data.hash);
         phase_in      = pop_data.nonempty ? PH_HEX : PH_SEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         phase_ff      <= PH_SEP;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         phase_ff      <= phase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
      hash_ff  <= hash_in;
      sep_ff   <= sep_in;
      char_ff  <= char_in;
      end_ff   <= end_in;
   end

endmodule

`default_nettype wire

// File: design/path_segment_fnv1a_hasher_top.sv
// Top level of the path segment FNV-1a hasher.
//
//   channel  | ports                               | moves
//   ---------+-------------------------------------+-------------------------------------
//   request  | req_valid, req_ready, req_path_byte | one path byte per transfer
//   response | rsp_valid, rsp_ready, rsp_out_char, | one hex digit, separator or final
//            | rsp_path_end                        | NUL (rsp_path_end set) per transfer
//
// Segment bytes are never stalled and are absorbed by the front-end hash register.
// A boundary byte enters the boundary queue (QueueDepth entries); the back end then
// emits 1 to 9 chars through the output register, one per cycle when not stalled.
// req_ready drops for a boundary byte only while the queue is full.
// Reset is synchronous and clears the hash, the queue and the output valid.
`default_nettype none

module path_segment_fnv1a_hasher_top #(
   parameter int QueueDepth = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_path_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_path_end
);
   import pfh_pkg::*;

   logic       push_valid, push_ready;
   qentry_type push_data;
   logic       pop_valid, pop_ready;
   qentry_type pop_data;

   pfh_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_path_byte (req_path_byte),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_data     (push_data)
   );

   pfh_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   pfh_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_data     (pop_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_path_end (rsp_path_end)
   );

endmodule

`default_nettype wire

// File: bench/path_segment_fnv1a_hasher_top_test.sv
// Self-checking testbench for the path segment FNV-1a hasher: random paths against a predictor.
`default_nettype none

module path_segment_fnv1a_hasher_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pfh_pkg::*;

   typedef logic [7:0] path_bytes_type[$];

   localparam int unsigned TotalBytes   = 430;
   localparam int unsigned IdleLimit    = 2000;
   localparam int unsigned DrainCycles  = 24;
   localparam int unsigned StallPercent = 30;

   // Predicts the character stream of the hasher and checks it against the output.
   class segment_hash_scoreboard;
      typedef struct {
         logic [7:0] ch;
         logic       last;
      } out_char_type;

      logic [31:0]  seg_hash;
      bit           seg_open;
      out_char_type expected_chars[$];
      int unsigned  mismatches;

      function new();
         seg_hash    = FnvOffsetBasis;
         seg_open    = 1'b0;
         mismatches  = 0;
      endfunction

      static function logic [31:0] fold(logic [31:0] h, logic [7:0] b);
         return (h ^ {24'h0, b}) * FnvPrime;
      endfunction

      static function bit ends_segment(logic [7:0] b);
         case (b)
            CharSlash, CharBackslash, CharDot, CharStar, CharNul: return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      function int pending();
         return expected_chars.size();
      endfunction

      // One accepted path byte: fold it, or flush the segment digits and the boundary
      function void note_path_byte(logic [7:0] b);
         string digits;
         int    top;
         digits = "0123456789abcdef";
         if (!ends_segment(b)) begin
            seg_hash = fold(seg_hash, b);
            seg_open = 1'b1;
            return;
         end
         if (seg_open) begin
            // no leading zeros, but a zero hash still gives one digit
            top = 7;
            while (top > 0 && seg_hash[4*top +: 4] == 4'h0) top--;
            for (int i = top; i >= 0; i--) begin
               expected_chars.push_back('{ch: digits[seg_hash[4*i +: 4]], last: 1'b0});
            end
         end
         expected_chars.push_back('{ch: b, last: (b == CharNul)});
         seg_hash = FnvOffsetBasis;
         seg_open = 1'b0;
      endfunction

      // One accepted output character against the oldest prediction
      task check_char(logic [7:0] ch, logic last);
         out_char_type exp;
         if (expected_chars.size() == 0) begin
            report($sformatf("output char %02h (end %0b) with nothing expected", ch, last));
            return;
         end
         exp = expected_chars.pop_front();
         if (ch !== exp.ch) begin
            report($sformatf("out_char %02h, expected %02h", ch, exp.ch));
         end
         if (last !== exp.last) begin
            report($sformatf("path_end %0b, expected %0b (char %02h)", last, exp.last, exp.ch));
         end
      endtask
   endclass

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_ready;
   logic [7:0] req_path_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready     = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_path_end;

   segment_hash_scoreboard sb;
   int unsigned bytes_sent  = 0;
   int unsigned cycle_count = 0;
   int unsigned idle_cycles = 0;

   path_segment_fnv1a_hasher_top u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_path_byte (req_path_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_path_end  (rsp_path_end)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver: random stalls, with a steady window of full throughput
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (cycle_count >= 700 && cycle_count < 1100) ||
                      ($urandom_range(99) >= StallPercent);
      end
   end

   // Output check on every response transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_char(rsp_out_char, rsp_path_end);
      end
   end

   // Watchdog: cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Drive one path byte, idling first at random outside the steady window
   task automatic push_path_byte(input logic [7:0] b);
      while (!(bytes_sent >= 200 && bytes_sent < 300) && $urandom_range(99) < StallPercent) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_path_byte <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_path_byte(b);
      bytes_sent++;
   endtask

   task automatic send_path(input path_bytes_type bytes);
      foreach (bytes[i]) push_path_byte(bytes[i]);
   endtask

   // Mostly text-like bytes, sometimes any byte (boundaries included)
   function automatic logic [7:0] random_segment_byte();
      string letters;
      letters = "abcdefghijklmnopqrstuvwxyzABCZ0123456789_-";
      if ($urandom_range(9) < 7) begin
         return letters[$urandom_range(letters.len() - 1)];
      end
      return 8'($urandom_range(255));
   endfunction

   function automatic path_bytes_type random_path();
      path_bytes_type p;
      string          seps;
      int unsigned    seg_len;
      seps = "/\\.*";
      repeat ($urandom_range(5, 1)) begin
         seg_len = ($urandom_range(19) == 0) ? $urandom_range(40, 20) : $urandom_range(8);
         repeat (seg_len) p.push_back(random_segment_byte());
         p.push_back(seps[$urandom_range(3)]);
      end
      // segment right before the terminator most of the time
      if ($urandom_range(3) != 0) begin
         repeat ($urandom_range(6, 1)) p.push_back(random_segment_byte());
      end
      p.push_back(CharNul);
      return p;
   endfunction

   // Five segment bytes whose hash is zero: a 3-byte prefix, then two bytes chosen so the
   // value before the last fold equals the last byte itself
   function automatic path_bytes_type zero_hash_segment();
      logic [31:0] prime_inv;
      logic [31:0] h1, h2, h3, target;
      logic [7:0]  last_of [logic [23:0]];
      logic [7:0]  mid;
      prime_inv = FnvPrime;
      repeat (5) prime_inv = prime_inv * (32'd2 - FnvPrime * prime_inv);
      for (int d = 1; d < 256; d++) begin
         if (!segment_hash_scoreboard::ends_segment(8'(d))) begin
            target = 32'(d) * prime_inv;
            last_of[target[31:8]] = 8'(d);
         end
      end
      for (int a = 1; a < 256; a++) begin
         if (segment_hash_scoreboard::ends_segment(8'(a))) continue;
         h1 = segment_hash_scoreboard::fold(FnvOffsetBasis, 8'(a));
         for (int b = 1; b < 256; b++) begin
            if (segment_hash_scoreboard::ends_segment(8'(b))) continue;
            h2 = segment_hash_scoreboard::fold(h1, 8'(b));
            for (int c = 1; c < 256; c++) begin
               if (segment_hash_scoreboard::ends_segment(8'(c))) continue;
               h3 = segment_hash_scoreboard::fold(h2, 8'(c));
               if (last_of.exists(h3[31:8])) begin
                  target = 32'(last_of[h3[31:8]]) * prime_inv;
                  mid    = h3[7:0] ^ target[7:0];
                  if (!segment_hash_scoreboard::ends_segment(mid)) begin
                     return '{8'(a), 8'(b), 8'(c), mid, last_of[h3[31:8]]};
                  end
               end
            end
         end
      end
      return '{8'h7A};
   endfunction

   initial begin
      path_bytes_type directed;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty path, leading and doubled separators, NUL after a separator,
      // one-byte segment, extreme byte values, zero-hash segment
      directed = '{CharNul,
                   CharSlash, CharSlash, CharDot, CharNul,
                   8'h61, CharNul,
                   8'hFF, 8'h01, 8'h80, 8'h7F, 8'h2B, CharBackslash};
      directed = {directed, zero_hash_segment(), CharStar, 8'hFE, CharNul};
      send_path(directed);

      while (bytes_sent < TotalBytes) send_path(random_path());
      req_valid <= 1'b0;

      // Drain: everything predicted must come out, then watch for strays
      while (sb.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
